[rtl/one_wire_bus_master_defines.svh]
// Assertion helpers used by owm_core.
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define OWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define OWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/owm_pkg.sv]
package owm_pkg;

  localparam int MAX_BYTES  = 8;
  localparam int TIMER_BITS = 10;
  localparam int WORD_BITS  = 64;
  localparam int POS_BITS   = 6;
  localparam int BL_BITS    = 7;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [1:0] DRV_REL  = 2'd0;
  localparam logic [1:0] DRV_LOW  = 2'd1;
  localparam logic [1:0] DRV_HIGH = 2'd2;

  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_START_MARK    = 3'd3;
  localparam logic [2:0] REG_WRITE_SLOT    = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [2:0] REG_READ_TAIL     = 3'd6;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] presence_wait_time;
    logic [9:0] reset_tail_time;
    logic [5:0] start_mark_time;
    logic [9:0] write_slot_time;
    logic [9:0] read_sample_time;
    logic [9:0] read_tail_time;
  } owm_cfg_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [WORD_BITS-1:0] data_word;
    logic [3:0]           byte_count;
    logic                 line_level;
  } owm_item_t;

  typedef struct packed {
    logic [1:0]           line_drive;
    logic                 busy_res;
    logic                 done_res;
    logic                 presence;
    logic [WORD_BITS-1:0] read_word;
    logic                 rejected;
  } owm_res_t;

endpackage

[rtl/one_wire_bus_master.sv]
// A beat waits in the input register and its result in the result register; the result
// register loads only when the output is not stalled. A beat is one timer/phase update.
// Throughput: one input beat per clock cycle unless the output stalls.
// The input register and the result register each hold one beat, so while the output
// stalls one more input beat is taken and then in_ready drops.
// Reset (rst_n low, synchronous): core idle, drive released, config back to defaults.
module one_wire_bus_master (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [owm_pkg::WORD_BITS-1:0] in_data_word,
  input  logic [3:0]                    in_byte_count,
  input  logic                          in_line_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_line_drive,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic                          out_presence,
  output logic [owm_pkg::WORD_BITS-1:0] out_read_word,
  output logic                          out_rejected,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [9:0]                    cfg_data
);

  owm_pkg::owm_item_t item_r;
  owm_pkg::owm_res_t  res_r, res;
  owm_pkg::owm_cfg_t  cfg;
  logic               item_valid_r;
  logic               out_valid_r;
  logic               step_en;

  assign cfg_ready = 1'b1;
  assign step_en   = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !item_valid_r || step_en;

  owm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid_r <= 1'b1;
      end else if (step_en) begin
        item_valid_r <= 1'b0;
      end
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind       <= in_kind;
      item_r.data_word  <= in_data_word;
      item_r.byte_count <= in_byte_count;
      item_r.line_level <= in_line_level;
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_drive = res_r.line_drive;
  assign out_busy_res   = res_r.busy_res;
  assign out_done_res   = res_r.done_res;
  assign out_presence   = res_r.presence;
  assign out_read_word  = res_r.read_word;
  assign out_rejected   = res_r.rejected;

endmodule

[rtl/owm_cfg.sv]
module owm_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [9:0]        wr_data,
  output owm_pkg::owm_cfg_t cfg
);

  owm_pkg::owm_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_time     <= 10'd500;
      cfg_r.presence_wait_time <= 10'd118;
      cfg_r.reset_tail_time    <= 10'd130;
      cfg_r.start_mark_time    <= 6'd2;
      cfg_r.write_slot_time    <= 10'd70;
      cfg_r.read_sample_time   <= 10'd20;
      cfg_r.read_tail_time     <= 10'd40;
    end else if (wr_en) begin
      unique case (wr_index)
        owm_pkg::REG_RESET_LOW:     cfg_r.reset_low_time     <= wr_data;
        owm_pkg::REG_PRESENCE_WAIT: cfg_r.presence_wait_time <= wr_data;
        owm_pkg::REG_RESET_TAIL:    cfg_r.reset_tail_time    <= wr_data;
        owm_pkg::REG_START_MARK:    cfg_r.start_mark_time    <= wr_data[5:0];
        owm_pkg::REG_WRITE_SLOT:    cfg_r.write_slot_time    <= wr_data;
        owm_pkg::REG_READ_SAMPLE:   cfg_r.read_sample_time   <= wr_data;
        owm_pkg::REG_READ_TAIL:     cfg_r.read_tail_time     <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/owm_core.sv]
`include "one_wire_bus_master_defines.svh"

module owm_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  owm_pkg::owm_item_t item,
  input  owm_pkg::owm_cfg_t  cfg,
  output owm_pkg::owm_res_t  res
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_HIGH,
    PH_RST_REL,
    PH_RST_TAIL,
    PH_WR_MARK,
    PH_WR_DATA,
    PH_WR_REC,
    PH_RD_MARK,
    PH_RD_REL,
    PH_RD_TAIL
  } phase_t;

  phase_t                            phase_r, phase_nxt;
  logic [owm_pkg::TIMER_BITS-1:0]    timer_r, timer_nxt;
  logic [owm_pkg::BL_BITS-1:0]       bits_left_r, bits_left_nxt, bl_dec;
  logic [owm_pkg::WORD_BITS-1:0]     shift_r, shift_nxt;
  logic [owm_pkg::POS_BITS-1:0]      pos_r, pos_nxt;
  logic                              pres_seen_r, pres_seen_nxt;
  logic [1:0]                        drive_r, drive_nxt;
  logic [3:0]                        count;
  logic [owm_pkg::TIMER_BITS-1:0]    mark_time;

  assign mark_time = owm_pkg::TIMER_BITS'(cfg.start_mark_time);
  assign bl_dec    = (bits_left_r != '0) ? bits_left_r - 1'b1 : '0;

  always_comb begin
    if (item.byte_count == 4'd0) begin
      count = 4'd1;
    end else if (item.byte_count > 4'(owm_pkg::MAX_BYTES)) begin
      count = 4'(owm_pkg::MAX_BYTES);
    end else begin
      count = item.byte_count;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    timer_nxt     = timer_r;
    bits_left_nxt = bits_left_r;
    shift_nxt     = shift_r;
    pos_nxt       = pos_r;
    pres_seen_nxt = pres_seen_r;
    drive_nxt     = drive_r;
    res           = '0;

    if (item.kind == owm_pkg::KIND_TICK) begin
      if (phase_r != PH_IDLE) begin
        if (timer_r <= owm_pkg::TIMER_BITS'(1)) begin
          unique case (phase_r)
            PH_RST_LOW: begin
              phase_nxt = PH_RST_HIGH;
              drive_nxt = owm_pkg::DRV_HIGH;
              timer_nxt = mark_time;
            end
            PH_RST_HIGH: begin
              phase_nxt = PH_RST_REL;
              drive_nxt = owm_pkg::DRV_REL;
              timer_nxt = owm_pkg::TIMER_BITS'(cfg.presence_wait_time);
            end
            PH_RST_REL: begin
              pres_seen_nxt = !item.line_level;
              phase_nxt     = PH_RST_TAIL;
              drive_nxt     = owm_pkg::DRV_REL;
              timer_nxt     = owm_pkg::TIMER_BITS'(cfg.reset_tail_time);
            end
            PH_RST_TAIL: begin
              phase_nxt    = PH_IDLE;
              drive_nxt    = owm_pkg::DRV_REL;
              res.done_res = 1'b1;
              res.presence = pres_seen_r;
            end
            PH_WR_MARK: begin
              phase_nxt = PH_WR_DATA;
              drive_nxt = shift_r[pos_r] ? owm_pkg::DRV_HIGH : owm_pkg::DRV_LOW;
              timer_nxt = owm_pkg::TIMER_BITS'(cfg.write_slot_time);
            end
            PH_WR_DATA: begin
              phase_nxt = PH_WR_REC;
              drive_nxt = owm_pkg::DRV_HIGH;
              timer_nxt = mark_time;
            end
            PH_WR_REC: begin
              bits_left_nxt = bl_dec;
              pos_nxt       = pos_r + 1'b1;
              if (bl_dec == '0) begin
                phase_nxt    = PH_IDLE;
                drive_nxt    = owm_pkg::DRV_HIGH;
                res.done_res = 1'b1;
              end else begin
                phase_nxt = PH_WR_MARK;
                drive_nxt = owm_pkg::DRV_LOW;
                timer_nxt = mark_time;
              end
            end
            PH_RD_MARK: begin
              phase_nxt = PH_RD_REL;
              drive_nxt = owm_pkg::DRV_REL;
              timer_nxt = owm_pkg::TIMER_BITS'(cfg.read_sample_time);
            end
            PH_RD_REL: begin
              if (item.line_level) begin
                shift_nxt[pos_r] = 1'b1;
              end
              phase_nxt = PH_RD_TAIL;
              drive_nxt = owm_pkg::DRV_REL;
              timer_nxt = owm_pkg::TIMER_BITS'(cfg.read_tail_time);
            end
            PH_RD_TAIL: begin
              bits_left_nxt = bl_dec;
              pos_nxt       = pos_r + 1'b1;
              if (bl_dec == '0) begin
                phase_nxt     = PH_IDLE;
                drive_nxt     = owm_pkg::DRV_REL;
                res.done_res  = 1'b1;
                res.read_word = shift_r;
              end else begin
                phase_nxt = PH_RD_MARK;
                drive_nxt = owm_pkg::DRV_LOW;
                timer_nxt = mark_time;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end else begin
          timer_nxt = timer_r - 1'b1;
        end
      end
    end else if (phase_r != PH_IDLE) begin
      res.rejected = 1'b1;
    end else if (item.kind == owm_pkg::KIND_RESET) begin
      pres_seen_nxt = 1'b0;
      phase_nxt     = PH_RST_LOW;
      drive_nxt     = owm_pkg::DRV_LOW;
      timer_nxt     = owm_pkg::TIMER_BITS'(cfg.reset_low_time);
    end else begin
      bits_left_nxt = owm_pkg::BL_BITS'({count, 3'b000});
      pos_nxt       = '0;
      drive_nxt     = owm_pkg::DRV_LOW;
      timer_nxt     = mark_time;
      if (item.kind == owm_pkg::KIND_WRITE) begin
        shift_nxt = item.data_word;
        phase_nxt = PH_WR_MARK;
      end else begin
        shift_nxt = '0;
        phase_nxt = PH_RD_MARK;
      end
    end

    res.line_drive = drive_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      timer_r     <= '0;
      bits_left_r <= '0;
      shift_r     <= '0;
      pos_r       <= '0;
      pres_seen_r <= 1'b0;
      drive_r     <= owm_pkg::DRV_REL;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      bits_left_r <= bits_left_nxt;
      shift_r     <= shift_nxt;
      pos_r       <= pos_nxt;
      pres_seen_r <= pres_seen_nxt;
      drive_r     <= drive_nxt;
    end
  end

  `OWM_ASSERT_NOW(a_done_idle, step_en && res.done_res, !res.busy_res, "done while still busy")
  `OWM_ASSERT_NOW(a_reject_busy, step_en && res.rejected, phase_r != PH_IDLE, "reject while idle")
  `OWM_ASSERT_NOW(a_pres_done, res.presence, res.done_res, "presence without done")
  `OWM_ASSERT_NEXT(a_reject_hold, step_en && res.rejected,
                   phase_r == $past(phase_r) && timer_r == $past(timer_r),
                   "rejected command changed state")
  `OWM_ASSERT_NOW(a_busy_bits, phase_r == PH_WR_REC || phase_r == PH_RD_TAIL,
                  bits_left_r != '0, "slot running with no bits left")

endmodule
